// File: rtl/bdqs_pkg.sv
// Shared types, constants and codes of the bounded deque with search.
`default_nettype none

package bdqs_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request codes
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_REAR  = 3'd1;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
    localparam logic [2:0] REQ_DEL_REAR  = 3'd3;
    localparam logic [2:0] REQ_SEARCH    = 3'd4;
    localparam logic [2:0] REQ_LIST      = 3'd5;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FOUND   = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;
    localparam logic [2:0] ST_ELEMENT = 3'd5;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_value;
        logic signed [31:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic               last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_TAKE_PREV = 2'd2,
        CELL_TAKE_NEXT = 2'd3
    } t_cell_op;

    // control of the whole cell row for one cycle
    typedef struct packed {
        logic             shift_right;
        logic             rotate;
        logic             load_at;
        logic [IDX_W-1:0] idx;
    } t_row_ctl;

endpackage

`default_nettype wire

// File: rtl/bounded_deque_with_search_unit.sv
// Top level of the bounded deque with search: request decode, walk sequencer, result register.
`default_nettype none

// Bounded double-ended queue of up to DEPTH signed 32-bit values, kept in
// order in a ring of cells with the front element in cell 0 outside a walk. One
// request is worked on at a time. Inserts and deletes finish in the cycle
// the request transaction is taken and give one result; a full insert
// answers "list full", a delete on an empty deque answers "list empty".
// Search and list walk the ring: each cycle in which the result register
// is free, every cell passes its value to its left neighbor while cell 0
// is compared with the key or sent out, and after exactly DEPTH steps the
// ring is back in its original order. A search or list therefore keeps
// the input stalled until its walk is over, plus any cycles in which the
// result register is held by output stall. Search answers once,
// at the end of the walk; list gives one result per element, front to
// rear, with last_of_run on the final one. Request codes 6 and 7 are
// taken and dropped. The result register lets a request be taken while
// the previous result is still being handed over.
module bounded_deque_with_search_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  bdqs_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output bdqs_pkg::t_out_item  o_out_item
);
    import bdqs_pkg::*;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_WALK = 2'b10
    } t_fsm;

    t_fsm               r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_step,  n_step;
    logic               r_found, n_found;
    logic               r_list,  n_list;
    logic signed [31:0] r_key,   n_key;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_row_ctl           row_ctl;
    logic signed [31:0] front_val;
    logic signed [31:0] sel_val;

    logic out_free;
    logic in_acc;
    logic walk_adv;
    logic empty;
    logic full;
    logic in_run;
    logic match;
    logic last_step;

    bdqs_cell_row u_row (
        .i_clk   (i_clk),
        .i_ctl   (row_ctl),
        .i_item  (i_in_item.item_value),
        .o_front (front_val),
        .o_sel   (sel_val)
    );

    // The result register frees up when empty or when its transaction goes out.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == FSM_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign walk_adv   = (r_state == FSM_WALK) && out_free;

    assign empty     = (r_count == '0);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign in_run    = CNT_W'(r_step) < r_count;
    assign match     = in_run && (front_val == r_key);
    assign last_step = (r_step == IDX_W'(DEPTH - 1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_found     = r_found;
        n_list      = r_list;
        n_key       = r_key;
        // drop the held result once taken
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        row_ctl.shift_right = 1'b0;
        row_ctl.rotate      = 1'b0;
        row_ctl.load_at     = 1'b0;
        row_ctl.idx         = r_count[IDX_W-1:0];

        if (in_acc) begin
            n_out.out_value   = '0;
            n_out.last_of_run = 1'b1;
            case (i_in_item.req_type)
                REQ_INS_FRONT: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        // push every element one cell toward the rear
                        row_ctl.shift_right = 1'b1;
                        n_count             = r_count + 1'b1;
                        n_out.status        = ST_DONE;
                    end
                end
                REQ_INS_REAR: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        // write just past the current rear
                        row_ctl.load_at = 1'b1;
                        n_count         = r_count + 1'b1;
                        n_out.status    = ST_DONE;
                    end
                end
                REQ_DEL_FRONT: begin
                    n_out_valid = 1'b1;
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        // pull every element one cell toward the front
                        row_ctl.rotate  = 1'b1;
                        n_count         = r_count - 1'b1;
                        n_out.status    = ST_DONE;
                        n_out.out_value = front_val;
                    end
                end
                REQ_DEL_REAR: begin
                    n_out_valid = 1'b1;
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        row_ctl.idx     = IDX_W'(r_count - 1'b1);
                        n_count         = r_count - 1'b1;
                        n_out.status    = ST_DONE;
                        n_out.out_value = sel_val;
                    end
                end
                REQ_SEARCH, REQ_LIST: begin
                    if (empty) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ST_EMPTY;
                    end else begin
                        // start a full turn of the ring
                        n_state = FSM_WALK;
                        n_step  = '0;
                        n_found = 1'b0;
                        n_key   = i_in_item.search_key;
                        n_list  = (i_in_item.req_type == REQ_LIST);
                    end
                end
                default: begin
                    // unused codes: take and drop
                end
            endcase
        end else if (walk_adv) begin
            // advance the ring one cell; cell 0 shows element r_step
            row_ctl.rotate = 1'b1;
            n_step         = r_step + 1'b1;
            n_found        = r_found || match;
            if (r_list && in_run) begin
                n_out_valid       = 1'b1;
                n_out.status      = ST_ELEMENT;
                n_out.out_value   = front_val;
                n_out.last_of_run = ((CNT_W'(r_step) + 1'b1) == r_count);
            end
            if (last_step) begin
                n_state = FSM_IDLE;
                if (!r_list) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = (r_found || match) ? ST_FOUND : ST_MISSING;
                    n_out.out_value   = '0;
                    n_out.last_of_run = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_found <= n_found;
        r_list  <= n_list;
        r_key   <= n_key;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_WALK) |-> o_in_stall)
        else $error("input taken during a ring walk");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_adv && last_step && !r_list) |=> (r_state == FSM_IDLE) && o_out_valid)
        else $error("search walk did not finish with a result");

    a_walk_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_WALK) |=> $stable(r_count))
        else $error("element count changed during a ring walk");
`endif

endmodule

`default_nettype wire

// File: rtl/bdqs_cell.sv
// One storage cell of the deque row: holds one element and trades with its neighbors.
`default_nettype none

module bdqs_cell (
    input  wire                 i_clk,
    input  bdqs_pkg::t_cell_op  i_op,
    input  wire signed [31:0]   i_load,
    input  wire signed [31:0]   i_prev,
    input  wire signed [31:0]   i_next,
    output logic signed [31:0]  o_value
);
    import bdqs_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        case (i_op)
            CELL_HOLD:      n_value = r_value;
            CELL_LOAD:      n_value = i_load;
            CELL_TAKE_PREV: n_value = i_prev;
            CELL_TAKE_NEXT: n_value = i_next;
            default:        n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// File: rtl/bdqs_cell_row.sv
// Ring of deque cells, front element in cell 0, with per-cell op decode and rear read port.
`default_nettype none

module bdqs_cell_row (
    input  wire                 i_clk,
    input  bdqs_pkg::t_row_ctl  i_ctl,
    input  wire signed [31:0]   i_item,
    output logic signed [31:0]  o_front,
    output logic signed [31:0]  o_sel
);
    import bdqs_pkg::*;

    logic signed [31:0] cell_val [DEPTH];
    t_cell_op           cell_op  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_comb begin
            if (i_ctl.shift_right) begin
                cell_op[g] = (g == 0) ? CELL_LOAD : CELL_TAKE_PREV;
            end else if (i_ctl.rotate) begin
                cell_op[g] = CELL_TAKE_NEXT;
            end else if (i_ctl.load_at && (i_ctl.idx == IDX_W'(g))) begin
                cell_op[g] = CELL_LOAD;
            end else begin
                cell_op[g] = CELL_HOLD;
            end
        end

        bdqs_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_load  (i_item),
            .i_prev  (cell_val[(g + DEPTH - 1) % DEPTH]),
            .i_next  (cell_val[(g + 1) % DEPTH]),
            .o_value (cell_val[g])
        );
    end

    assign o_front = cell_val[0];
    assign o_sel   = cell_val[i_ctl.idx];

endmodule

`default_nettype wire
